// File: design/ortlb_pkg.sv
// Shared types and constants for the optimal-replacement TLB model.
package ortlb_pkg;

    localparam int unsigned CpuCountDefault   = 4;
    localparam int unsigned SetCountDefault   = 512;
    localparam int unsigned WayCountDefault   = 4;
    localparam int unsigned CounterWidthDef   = 48;
    localparam int unsigned TotalWidth        = 48;
    localparam logic [62:0] NeverAgain        = {63{1'b1}};

    localparam logic KindAccess = 1'b0;
    localparam logic KindProbe  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  cpu_number;
        logic [63:0] page;
        logic signed [63:0] next_use_time;
        logic        trace_said_miss;
    } t_in;

    typedef struct packed {
        logic        tlb_hit;
        logic        trace_mismatch;
        logic        causality_flag;
        logic        resident_anywhere;
        logic [TotalWidth-1:0] access_total;
        logic [TotalWidth-1:0] eviction_total;
        logic [TotalWidth-1:0] mismatch_total;
        logic [TotalWidth-1:0] resident_evict_total;
        logic [TotalWidth-1:0] causality_total;
    } t_out;

    // Classified transaction passed from front to back.
    typedef struct packed {
        logic        kind;
        logic [3:0]  cpu;
        logic [63:0] page;
        logic [62:0] next_use;
        logic        said_miss;
    } t_cmd;

endpackage

// File: design/ortlb_front.sv
// Front: accept input transactions, classify and queue them for the back end.
module ortlb_front #(
    parameter int unsigned CPU_COUNT = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ortlb_pkg::t_in  i_data,
    output logic            o_cmd_valid,
    input  logic            i_cmd_take,
    output ortlb_pkg::t_cmd o_cmd
);
    import ortlb_pkg::*;

    localparam int unsigned CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_cmd        w_cmd;
    logic        w_push, w_pop;

    always_comb begin
        w_cmd = '0;
        w_cmd.kind      = i_data.kind;
        w_cmd.page      = i_data.page;
        w_cmd.said_miss = i_data.trace_said_miss;
        w_cmd.next_use  = i_data.next_use_time[63] ? NeverAgain
                                                   : i_data.next_use_time[62:0];
        if (32'(i_data.cpu_number) < CPU_COUNT) begin
            w_cmd.cpu = 4'(i_data.cpu_number[CW-1:0]);
        end
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// File: design/ortlb_back.sv
// Back: sweep valid bits after reset, look up and update the TLB memories.
module ortlb_back #(
    parameter int unsigned CPU_COUNT     = 4,
    parameter int unsigned SET_COUNT     = 512,
    parameter int unsigned WAY_COUNT     = 4,
    parameter int unsigned COUNTER_WIDTH = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_take,
    input  ortlb_pkg::t_cmd i_cmd,
    output logic            o_valid,
    input  logic            i_stall,
    output ortlb_pkg::t_out o_data
);
    import ortlb_pkg::*;

    localparam int unsigned SW    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int unsigned CW    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int unsigned RW    = CW + SW;
    localparam int unsigned ROWS  = CPU_COUNT * SET_COUNT;
    localparam int unsigned WW    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int unsigned CTW   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT + 1) : 1;
    localparam logic [COUNTER_WIDTH-1:0] CMax = '1;

    localparam logic [2:0] StClear = 3'd0;
    localparam logic [2:0] StIdle  = 3'd1;
    localparam logic [2:0] StRead  = 3'd2;
    localparam logic [2:0] StEval  = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;

    logic [WAY_COUNT-1:0]        r_vmem [ROWS];
    logic [WAY_COUNT-1:0][63:0]  r_pmem [ROWS];
    logic [WAY_COUNT-1:0][62:0]  r_tmem [ROWS];

    logic [2:0]  r_st;
    logic [RW:0] r_clr;
    t_cmd        r_cmd;
    logic [CTW-1:0] r_cpu;
    logic [WAY_COUNT-1:0]       r_v;
    logic [WAY_COUNT-1:0][63:0] r_p;
    logic [WAY_COUNT-1:0][62:0] r_t;
    logic        r_res;
    logic [3:0]  r_fl;
    logic [COUNTER_WIDTH-1:0] r_acc, r_evi, r_mis, r_rev, r_cau;
    logic        r_oval;
    t_out        r_out;

    logic [SW-1:0] w_set;
    logic [RW-1:0] w_raddr;
    logic [WAY_COUNT-1:0] w_match;
    logic        w_hit, w_free, w_caus, w_mis;
    logic [WW-1:0] w_hw, w_vw;

    function automatic logic [SW-1:0] set_of(input logic [63:0] p);
        return SW'(p % 64'(SET_COUNT));
    endfunction

    function automatic logic [RW-1:0] row_of(input logic [CW-1:0] c,
                                             input logic [SW-1:0] s);
        logic [RW-1:0] r;
        r = RW'(c) * RW'(SET_COUNT) + RW'(s);
        return r;
    endfunction

    assign w_set   = set_of(r_cmd.page);
    assign w_raddr = row_of((r_cmd.kind == KindProbe) ? CW'(r_cpu) : CW'(r_cmd.cpu),
                            w_set);

    always_comb begin
        w_hw = '0; w_vw = '0; w_free = 1'b0;
        for (int w = 0; w < WAY_COUNT; w++) begin
            w_match[w] = r_v[w] && (r_p[w] == r_cmd.page);
        end
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (w_match[w]) w_hw = WW'(w);
            if (!r_v[w]) begin
                w_vw = WW'(w);
                w_free = 1'b1;
            end
        end
        if (!w_free) begin
            for (int w = 1; w < WAY_COUNT; w++) begin
                if (r_t[w] > r_t[w_vw]) w_vw = WW'(w);
            end
        end
        w_hit  = |w_match;
        w_caus = w_hit && (r_cmd.next_use <= r_t[w_hw]);
        w_mis  = (w_hit == r_cmd.said_miss);
    end

    function automatic logic [COUNTER_WIDTH-1:0] bump(input logic [COUNTER_WIDTH-1:0] c);
        return (c == CMax) ? c : c + 1'b1;
    endfunction

    assign o_cmd_take = (r_st == StIdle) && i_cmd_valid;
    assign o_valid    = r_oval;
    assign o_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (r_st == StClear) begin
            r_vmem[r_clr[RW-1:0]] <= '0;
        end else if (r_st == StRead) begin
            r_v <= r_vmem[w_raddr];
            r_p <= r_pmem[w_raddr];
            r_t <= r_tmem[w_raddr];
        end else if (r_st == StEval && r_cmd.kind == KindAccess) begin
            if (w_hit) begin
                r_tmem[w_raddr][w_hw] <= r_cmd.next_use;
            end else begin
                r_vmem[w_raddr][w_vw] <= 1'b1;
                r_pmem[w_raddr][w_vw] <= r_cmd.page;
                r_tmem[w_raddr][w_vw] <= r_cmd.next_use;
            end
        end
        if (o_cmd_take) r_cmd <= i_cmd;
        if (!i_rst_n) begin
            r_st <= StClear; r_clr <= '0; r_oval <= 1'b0;
            r_acc <= '0; r_evi <= '0; r_mis <= '0; r_rev <= '0; r_cau <= '0;
        end else begin
            unique case (r_st)
                StClear: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (RW+1)'(ROWS - 1)) r_st <= StIdle;
                end
                StIdle: begin
                    if (i_cmd_valid) begin
                        r_st <= StRead; r_cpu <= '0; r_res <= 1'b0;
                    end
                end
                StRead: r_st <= StEval;
                StEval: begin
                    if (r_cmd.kind == KindAccess) begin
                        r_fl  <= {w_hit, w_mis, w_caus, 1'b0};
                        r_acc <= bump(r_acc);
                        if (w_caus) r_cau <= bump(r_cau);
                        if (w_mis)  r_mis <= bump(r_mis);
                        r_st <= StOut;
                    end else if (32'(r_cpu) == CPU_COUNT - 1) begin
                        r_fl  <= {3'b000, r_res || w_hit};
                        r_evi <= bump(r_evi);
                        if (r_res || w_hit) r_rev <= bump(r_rev);
                        r_st <= StOut;
                    end else begin
                        r_res <= r_res || w_hit;
                        r_cpu <= r_cpu + 1'b1;
                        r_st  <= StRead;
                    end
                end
                StOut: begin
                    if (!r_oval || !i_stall) begin
                        r_oval <= 1'b1;
                        r_out  <= '{tlb_hit:              r_fl[3],
                                    trace_mismatch:       r_fl[2],
                                    causality_flag:       r_fl[1],
                                    resident_anywhere:    r_fl[0],
                                    access_total:         TotalWidth'(r_acc),
                                    eviction_total:       TotalWidth'(r_evi),
                                    mismatch_total:       TotalWidth'(r_mis),
                                    resident_evict_total: TotalWidth'(r_rev),
                                    causality_total:      TotalWidth'(r_cau)};
                        r_st <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
            if (r_oval && !i_stall && r_st != StOut) r_oval <= 1'b0;
        end
    end
endmodule

// File: design/optimal_replacement_tlb_model.sv
// Top level of the per-CPU set-associative TLB model with optimal replacement.
// channel | direction | handshake         | payload
// input   | in        | i_valid / o_stall | i_data (t_in)
// output  | out       | o_valid / i_stall | o_data (t_out)
// In the back end an access passes the read-row, evaluate and write-out states in turn.
// A probe reads one row per CPU in turn, bound by the one row port.
// After reset a clearing pass over all CPU_COUNT*SET_COUNT rows zeroes the valid bits.
// A two-entry queue takes transactions while the back end works or the output stalls.
module optimal_replacement_tlb_model #(
    parameter int unsigned CPU_COUNT     = ortlb_pkg::CpuCountDefault,
    parameter int unsigned SET_COUNT     = ortlb_pkg::SetCountDefault,
    parameter int unsigned WAY_COUNT     = ortlb_pkg::WayCountDefault,
    parameter int unsigned COUNTER_WIDTH = ortlb_pkg::CounterWidthDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ortlb_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ortlb_pkg::t_out o_data
);
    import ortlb_pkg::*;

    logic w_cv, w_take;
    t_cmd w_cmd;

    ortlb_front #(.CPU_COUNT(CPU_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_cmd_valid(w_cv), .i_cmd_take(w_take), .o_cmd(w_cmd)
    );

    ortlb_back #(
        .CPU_COUNT(CPU_COUNT), .SET_COUNT(SET_COUNT),
        .WAY_COUNT(WAY_COUNT), .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_take(w_take), .i_cmd(w_cmd),
        .o_valid, .i_stall, .o_data
    );
endmodule

// File: design/ortlb_checker.sv
// Port-level checks for the TLB model, bound to the top level.
module ortlb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_valid,
    input logic            i_stall,
    input ortlb_pkg::t_out o_data
);
    import ortlb_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.resident_anywhere &&
                      (o_data.tlb_hit || o_data.causality_flag)))
        else $error("probe and access flags mixed");

    a_caus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.causality_flag |-> o_data.tlb_hit)
        else $error("causality flag without hit");

    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall ##1 o_valid |->
        o_data.access_total >= $past(o_data.access_total))
        else $error("access total decreased");
endmodule

bind optimal_replacement_tlb_model ortlb_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_data
);

// File: sim/optimal_replacement_tlb_model_tb.sv
// Testbench for the optimal-replacement TLB model: scoreboard-predicted random and directed traffic.
module optimal_replacement_tlb_model_tb;
    import ortlb_pkg::*;

    localparam int CpuCount = 4;
    localparam int SetCount = 512;
    localparam int WayCount = 4;
    localparam int EntryCount = CpuCount * SetCount * WayCount;
    localparam logic [47:0] CountMax = {48{1'b1}};

    class tlb_scoreboard;
        bit          valid_bit [EntryCount];
        logic [63:0] page_tag  [EntryCount];
        logic [62:0] next_use  [EntryCount];
        logic [47:0] access_cnt, probe_cnt, mismatch_cnt, resident_cnt, causality_cnt;
        t_out        pending [$];
        int          errors;
        int          hits, resident_hits, causal_hits;

        function void clear();
            foreach (valid_bit[i]) valid_bit[i] = 0;
            access_cnt = 0; probe_cnt = 0; mismatch_cnt = 0;
            resident_cnt = 0; causality_cnt = 0;
            errors = 0; hits = 0; resident_hits = 0; causal_hits = 0;
        endfunction

        function automatic logic [47:0] bump(logic [47:0] c);
            return (c == CountMax) ? c : c + 1;
        endfunction

        function void note_transaction(t_in t);
            t_out r;
            int cpu, base, victim, w;
            bit found, free;
            logic [62:0] nu;
            r = '0;
            if (t.kind == KindAccess) begin
                cpu = (t.cpu_number >= CpuCount) ? 0 : t.cpu_number;
                nu = t.next_use_time[63] ? NeverAgain : t.next_use_time[62:0];
                base = (cpu * SetCount + int'(t.page % SetCount)) * WayCount;
                access_cnt = bump(access_cnt);
                found = 0;
                for (w = 0; w < WayCount; w++) begin
                    if (!found && valid_bit[base+w] && page_tag[base+w] == t.page) begin
                        found = 1;
                        if (nu <= next_use[base+w]) r.causality_flag = 1;
                        next_use[base+w] = nu;
                    end
                end
                if (!found) begin
                    victim = 0;
                    free = 0;
                    for (w = 0; w < WayCount; w++) begin
                        if (!free && !valid_bit[base+w]) begin
                            victim = w;
                            free = 1;
                        end
                    end
                    if (!free) begin
                        for (w = 1; w < WayCount; w++)
                            if (next_use[base+w] > next_use[base+victim]) victim = w;
                    end
                    valid_bit[base+victim] = 1;
                    page_tag[base+victim] = t.page;
                    next_use[base+victim] = nu;
                end
                r.tlb_hit = found;
                if (r.causality_flag) begin
                    causality_cnt = bump(causality_cnt);
                    causal_hits++;
                end
                if (found == t.trace_said_miss) begin
                    r.trace_mismatch = 1;
                    mismatch_cnt = bump(mismatch_cnt);
                end
                if (found) hits++;
            end else begin
                probe_cnt = bump(probe_cnt);
                for (int c = 0; c < CpuCount; c++) begin
                    base = (c * SetCount + int'(t.page % SetCount)) * WayCount;
                    for (w = 0; w < WayCount; w++)
                        if (valid_bit[base+w] && page_tag[base+w] == t.page)
                            r.resident_anywhere = 1;
                end
                if (r.resident_anywhere) begin
                    resident_cnt = bump(resident_cnt);
                    resident_hits++;
                end
            end
            r.access_total = access_cnt;
            r.eviction_total = probe_cnt;
            r.mismatch_total = mismatch_cnt;
            r.resident_evict_total = resident_cnt;
            r.causality_total = causality_cnt;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch: %s got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check_result(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.tlb_hit !== e.tlb_hit) report("tlb_hit", got.tlb_hit, e.tlb_hit);
            if (got.trace_mismatch !== e.trace_mismatch)
                report("trace_mismatch", got.trace_mismatch, e.trace_mismatch);
            if (got.causality_flag !== e.causality_flag)
                report("causality_flag", got.causality_flag, e.causality_flag);
            if (got.resident_anywhere !== e.resident_anywhere)
                report("resident_anywhere", got.resident_anywhere, e.resident_anywhere);
            if (got.access_total !== e.access_total)
                report("access_total", got.access_total, e.access_total);
            if (got.eviction_total !== e.eviction_total)
                report("eviction_total", got.eviction_total, e.eviction_total);
            if (got.mismatch_total !== e.mismatch_total)
                report("mismatch_total", got.mismatch_total, e.mismatch_total);
            if (got.resident_evict_total !== e.resident_evict_total)
                report("resident_evict_total", got.resident_evict_total,
                       e.resident_evict_total);
            if (got.causality_total !== e.causality_total)
                report("causality_total", got.causality_total, e.causality_total);
        endtask
    endclass

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    t_in  i_data;
    t_out o_data;
    tlb_scoreboard sb;
    bit   quiet;
    int   sent;
    logic [63:0] page_pool [16];

    optimal_replacement_tlb_model i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("optimal_replacement_tlb_model_tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    initial begin : stall_gen
        int n;
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 0;
        end
    end

    task automatic send_item(t_in t);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            i_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1;
        i_data  <= t;
        do @(posedge i_clk); while (o_stall);
        sb.note_transaction(t);
        sent++;
    endtask

    function automatic t_in make_access(logic [7:0] cpu, logic [63:0] page,
                                        logic [63:0] nu, bit miss);
        t_in t;
        t.kind = KindAccess;
        t.cpu_number = cpu;
        t.page = page;
        t.next_use_time = nu;
        t.trace_said_miss = miss;
        return t;
    endfunction

    function automatic t_in make_probe(logic [63:0] page);
        t_in t;
        t = $bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        t.kind = KindProbe;
        t.page = page;
        return t;
    endfunction

    initial begin
        t_in t;
        int  guard;
        logic [63:0] pg;
        sb = new();
        sb.clear();
        quiet = 0;
        sent = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        for (int i = 0; i < 16; i++)
            page_pool[i] = {$urandom, $urandom} & ~64'h1ff | 64'(i % 3);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, never-again, cpu remap, causality, replacement, probes
        send_item(make_access(8'd0, 64'd0, 64'd100, 1'b1));
        send_item(make_access(8'd0, 64'd0, 64'd50, 1'b0));
        send_item(make_access(8'd0, 64'd0, 64'd200, 1'b1));
        send_item(make_access(8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0));
        send_item(make_access(8'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_access(8'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        for (int w = 0; w < 6; w++)
            send_item(make_access(8'd4, 64'h200 * (w + 1), 64'd10 * (6 - w), 1'b1));
        send_item(make_access(8'd0, 64'h200, 64'd5, 1'b0));
        send_item(make_probe(64'd0));
        send_item(make_probe(64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_probe(64'h1234_5678_9ABC_DEF0));
        send_item(make_probe(64'h400));
        send_item(make_access(8'd1, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 1'b1));
        send_item(make_probe(64'hAAAA_5555_AAAA_5555));

        for (int i = 0; i < 1250; i++) begin
            if (i > 1100) quiet = 1;
            case ($urandom_range(0, 9))
                0: t = $bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom});
                1, 2: begin
                    pg = page_pool[$urandom_range(0, 15)];
                    if ($urandom_range(0, 1)) pg = {$urandom, $urandom};
                    t = make_probe(pg);
                end
                default: begin
                    pg = page_pool[$urandom_range(0, 15)];
                    t = make_access(8'($urandom_range(0, 5)), pg,
                                    $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                                                            : 64'($urandom_range(0, 1000)),
                                    1'($urandom_range(0, 1)));
                end
            endcase
            send_item(t);
        end
        i_valid <= 0;
        quiet = 1;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.pending.size() != 0) sb.report("results left over", sb.pending.size(), 0);
        $display("covered %0d transactions: %0d hits, %0d causality flags, %0d resident probes",
                 sent, sb.hits, sb.causal_hits, sb.resident_hits);
        if (sb.errors == 0) begin
            $display("optimal_replacement_tlb_model_tb passed");
        end else begin
            $display("optimal_replacement_tlb_model_tb failed");
        end
        $finish;
    end
endmodule
